// File: src/rcsam_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsam_pkg
// Shared widths, codes, reset values and stage control type for the RC stick
// attitude command mapper.
// ----------------------------------------------------------------------------
package rcsam_pkg;

	// Field and register widths
	localparam int STICK_BITS = 12;
	localparam int FRAC_BITS  = 16;
	localparam int INV_FRAC   = 24;
	localparam int INV_W      = 24;
	localparam int THR_W      = 20;
	localparam int M_W        = 19;
	localparam int THRUST_W   = 24;
	localparam int CMD_W      = 20;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Expo lane datapath widths
	localparam int DIFF_W     = STICK_BITS + 1;
	localparam int NPROD_W    = STICK_BITS + INV_W;
	localparam int A_W        = FRAC_BITS + 1;
	localparam int A2_W       = FRAC_BITS - 2;
	localparam int LIN_W      = FRAC_BITS + 2;
	localparam int OP_W       = LIN_W;
	localparam int P_W        = M_W + OP_W;
	localparam int V_W        = M_W + 2;
	localparam int Q_W        = M_W;

	// Divide by 3 through a reciprocal: exact for any V_W-bit dividend
	localparam int DIV3_SH    = V_W + 2;
	localparam int DIV3_M_W   = DIV3_SH - 1;
	localparam int DIV3_PW    = V_W + DIV3_M_W;
	localparam logic [DIV3_M_W-1:0] DIV3_M = DIV3_M_W'((64'd1 << DIV3_SH) / 3 + 1);

	localparam logic [A_W-1:0] ONE  = A_W'(1) << FRAC_BITS;
	localparam logic [A_W-1:0] HALF = A_W'(1) << (FRAC_BITS - 1);

	// Thrust lane widths
	localparam int THR_D_W = STICK_BITS + 1;
	localparam int THR_P_W = THR_D_W + THR_W + 1;
	localparam logic signed [THR_P_W-1:0] THRUST_MAX = THR_P_W'((64'sd1 << (THRUST_W - 1)) - 1);
	localparam logic signed [THR_P_W-1:0] THRUST_MIN = -THR_P_W'(64'sd1 << (THRUST_W - 1));

	// Flight modes
	localparam logic [MODE_W-1:0] MODE_POS_HOLD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_STABILIZED = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MANUAL     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_OTHER      = 2'd3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_STICK_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STICK_MID    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_HALF     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRUST_PER   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRUST_FLOOR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TILT     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_YAW      = 3'd6;

	// Reset values
	localparam logic [STICK_BITS-1:0] RST_STICK_MIN    = 12'd1000;
	localparam logic [STICK_BITS-1:0] RST_STICK_MID    = 12'd1500;
	localparam logic [INV_W-1:0]      RST_INV_HALF     = 24'd33554;
	localparam logic [THR_W-1:0]      RST_THRUST_PER   = 20'd1303;
	localparam logic [THR_W-1:0]      RST_THRUST_FLOOR = 20'd7864;
	localparam logic [M_W-1:0]        RST_MAX_TILT     = 19'd34315;
	localparam logic [M_W-1:0]        RST_MAX_YAW      = 19'd102944;

	// Per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} rcsam_ld_t;

	// Expo lane result: magnitude and sign
	typedef struct packed {
		logic           neg;
		logic [Q_W-1:0] mag;
	} rcsam_lane_t;

endpackage

// File: src/rcsam_expo_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsam_expo_lane
// One stick channel: normalize about center, clamp to 1.0, expo curve with
// full scale m. Five stages, with one multiplier in each stage after the first.
// ----------------------------------------------------------------------------
module rcsam_expo_lane import rcsam_pkg::*; (
	input  logic                  clk,
	input  rcsam_ld_t             ld,
	input  logic [STICK_BITS-1:0] stick_count,
	input  logic [STICK_BITS-1:0] mid_count,
	input  logic [INV_W-1:0]      inv_half_range,
	input  logic [M_W-1:0]        full_scale,
	output rcsam_lane_t           lane
);

	// s1: magnitude and sign of the offset from center
	logic [DIFF_W-1:0]     diff;
	logic [STICK_BITS-1:0] mag_s1;
	logic                  neg_s1;

	assign diff = {1'b0, stick_count} - {1'b0, mid_count};

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			neg_s1 <= diff[DIFF_W-1];
			mag_s1 <= diff[DIFF_W-1] ? STICK_BITS'(-diff) : diff[STICK_BITS-1:0];
		end
	end

	// s2: scale by the reciprocal half range, clamp to 1.0
	logic [NPROD_W-1:0] nprod;
	logic [NPROD_W-1:0] norm;
	logic [A_W-1:0]     a_s2;
	logic               neg_s2;

	assign nprod = NPROD_W'(mag_s1) * NPROD_W'(inv_half_range);
	assign norm  = nprod >> (INV_FRAC - FRAC_BITS);

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			neg_s2 <= neg_s1;
			a_s2   <= (norm > NPROD_W'(ONE)) ? ONE : norm[A_W-1:0];
		end
	end

	// s3: pick the curve operand: x^2 on the inner part, 4x-1 on the outer
	logic [2*A_W-1:0] sq;
	logic [A2_W-1:0]  a2;
	logic [LIN_W-1:0] lin;
	logic             knee_lo;
	logic [OP_W-1:0]  op_s3;
	logic             knee_lo_s3;
	logic             neg_s3;

	assign sq      = (2*A_W)'(a_s2) * (2*A_W)'(a_s2);
	assign a2      = sq[FRAC_BITS +: A2_W];
	assign knee_lo = a_s2 < HALF;
	assign lin     = (LIN_W'(a_s2) << 2) - LIN_W'(ONE);

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			neg_s3     <= neg_s2;
			knee_lo_s3 <= knee_lo;
			op_s3      <= knee_lo ? OP_W'(a2) : lin;
		end
	end

	// s4: times full scale; inner part carries the factor 4 in its shift
	logic [P_W-1:0] prod;
	logic [V_W-1:0] v_s4;
	logic           neg_s4;

	assign prod = P_W'(full_scale) * P_W'(op_s3);

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			neg_s4 <= neg_s3;
			v_s4   <= knee_lo_s3 ? V_W'(prod >> (FRAC_BITS - 2)) : V_W'(prod >> FRAC_BITS);
		end
	end

	// s5: divide by 3
	logic [DIV3_PW-1:0] qprod;
	logic [Q_W-1:0]     q_s5;
	logic               neg_s5;

	assign qprod = DIV3_PW'(v_s4) * DIV3_PW'(DIV3_M);

	always_ff @(posedge clk) begin
		if (ld.s5) begin
			neg_s5 <= neg_s4;
			q_s5   <= qprod[DIV3_SH +: Q_W];
		end
	end

	assign lane.neg = neg_s5;
	assign lane.mag = q_s5;

endmodule

// File: src/rcsam_thrust_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsam_thrust_lane
// Throttle to thrust: linear map with saturation, delayed to line up with
// the expo lanes.
// ----------------------------------------------------------------------------
module rcsam_thrust_lane import rcsam_pkg::*; (
	input  logic                       clk,
	input  rcsam_ld_t                  ld,
	input  logic [STICK_BITS-1:0]      throttle_count,
	input  logic [STICK_BITS-1:0]      min_count,
	input  logic [THR_W-1:0]           thrust_per_count,
	input  logic [THR_W-1:0]           thrust_floor,
	output logic signed [THRUST_W-1:0] thrust
);

	logic signed [THR_D_W-1:0] d;
	logic signed [THR_P_W-1:0] prod_s1;
	logic signed [THR_P_W-1:0] sum;
	logic signed [THRUST_W-1:0] thr_s2, thr_s3, thr_s4, thr_s5;

	assign d = $signed({1'b0, throttle_count}) - $signed({1'b0, min_count});

	always_ff @(posedge clk) begin
		if (ld.s1)
			prod_s1 <= THR_P_W'(d) * THR_P_W'($signed({1'b0, thrust_per_count}));
	end

	assign sum = prod_s1 + THR_P_W'($signed({1'b0, thrust_floor}));

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			priority if (sum > THRUST_MAX)
				thr_s2 <= THRUST_W'(THRUST_MAX);
			else if (sum < THRUST_MIN)
				thr_s2 <= THRUST_W'(THRUST_MIN);
			else
				thr_s2 <= THRUST_W'(sum);
		end
		if (ld.s3)
			thr_s3 <= thr_s2;
		if (ld.s4)
			thr_s4 <= thr_s3;
		if (ld.s5)
			thr_s5 <= thr_s4;
	end

	assign thrust = thr_s5;

endmodule

// File: src/rcsam_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsam_merge
// Output stage: applies lane signs, zeroes the attitude terms outside manual
// mode and holds the result until it is taken.
// ----------------------------------------------------------------------------
module rcsam_merge import rcsam_pkg::*; (
	input  logic                       clk,
	input  logic                       ld_out,
	input  logic                       manual,
	input  logic signed [THRUST_W-1:0] thrust,
	input  rcsam_lane_t                roll,
	input  rcsam_lane_t                pitch,
	input  rcsam_lane_t                yaw,
	output logic signed [THRUST_W-1:0] thrust_cmd,
	output logic signed [CMD_W-1:0]    roll_cmd,
	output logic signed [CMD_W-1:0]    pitch_cmd,
	output logic signed [CMD_W-1:0]    yaw_rate_cmd
);

	function automatic logic [CMD_W-1:0] signed_cmd(input rcsam_lane_t l, input logic en);
		logic [CMD_W-1:0] m;
		m = CMD_W'(l.mag);
		if (!en)
			return '0;
		return l.neg ? -m : m;
	endfunction

	logic signed [THRUST_W-1:0] thrust_q;
	logic [CMD_W-1:0]           roll_q, pitch_q, yaw_q;

	always_ff @(posedge clk) begin
		if (ld_out) begin
			thrust_q <= thrust;
			roll_q   <= signed_cmd(roll, manual);
			pitch_q  <= signed_cmd(pitch, manual);
			yaw_q    <= signed_cmd(yaw, manual);
		end
	end

	assign thrust_cmd   = thrust_q;
	assign roll_cmd     = $signed(roll_q);
	assign pitch_cmd    = $signed(pitch_q);
	assign yaw_rate_cmd = $signed(yaw_q);

endmodule

// File: src/rc_stick_attitude_command_mapper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_stick_attitude_command_mapper
// Radio frame to thrust and attitude commands: throttle lane plus three expo
// lanes working side by side, merged in a registered output stage.
// ----------------------------------------------------------------------------
// One frame is taken per clock while in_ready is high. The transfer edge loads
// the first of five lane stages (normalize, clamp, square or linear operand,
// full-scale multiply, divide by 3) and the output register follows the last.
// Frames in position-hold or other mode are taken and give no result. Stalls
// on the output back up stage by stage, so bubbles are closed before
// in_ready drops. Registers are written through cfg_we/cfg_index/cfg_wdata
// and should only change while no frame is in flight.
// ----------------------------------------------------------------------------
module rc_stick_attitude_command_mapper import rcsam_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [MODE_W-1:0]          flight_mode,
	input  logic [STICK_BITS-1:0]      throttle_count,
	input  logic [STICK_BITS-1:0]      roll_count,
	input  logic [STICK_BITS-1:0]      pitch_count,
	input  logic [STICK_BITS-1:0]      yaw_count,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [THRUST_W-1:0] thrust_cmd,
	output logic signed [CMD_W-1:0]    roll_cmd,
	output logic signed [CMD_W-1:0]    pitch_cmd,
	output logic signed [CMD_W-1:0]    yaw_rate_cmd
);

	// Configuration registers
	logic [STICK_BITS-1:0] stick_min_q, stick_mid_q;
	logic [INV_W-1:0]      inv_half_q;
	logic [THR_W-1:0]      thrust_per_q, thrust_floor_q;
	logic [M_W-1:0]        max_tilt_q, max_yaw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stick_min_q    <= RST_STICK_MIN;
			stick_mid_q    <= RST_STICK_MID;
			inv_half_q     <= RST_INV_HALF;
			thrust_per_q   <= RST_THRUST_PER;
			thrust_floor_q <= RST_THRUST_FLOOR;
			max_tilt_q     <= RST_MAX_TILT;
			max_yaw_q      <= RST_MAX_YAW;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STICK_MIN:    stick_min_q    <= cfg_wdata[STICK_BITS-1:0];
				REG_STICK_MID:    stick_mid_q    <= cfg_wdata[STICK_BITS-1:0];
				REG_INV_HALF:     inv_half_q     <= cfg_wdata[INV_W-1:0];
				REG_THRUST_PER:   thrust_per_q   <= cfg_wdata[THR_W-1:0];
				REG_THRUST_FLOOR: thrust_floor_q <= cfg_wdata[THR_W-1:0];
				REG_MAX_TILT:     max_tilt_q     <= cfg_wdata[M_W-1:0];
				REG_MAX_YAW:      max_yaw_q      <= cfg_wdata[M_W-1:0];
				default: ;
			endcase
		end
	end

	// Stage valids and the manual flag, with a per-stage load chain
	logic      v_s1, v_s2, v_s3, v_s4, v_s5, out_valid_q;
	logic      man_s1, man_s2, man_s3, man_s4, man_s5;
	logic      ld_out;
	logic      keep;
	rcsam_ld_t ld;

	assign ld_out = !out_valid_q || out_ready;
	assign ld.s5  = !v_s5 || ld_out;
	assign ld.s4  = !v_s4 || ld.s5;
	assign ld.s3  = !v_s3 || ld.s4;
	assign ld.s2  = !v_s2 || ld.s3;
	assign ld.s1  = !v_s1 || ld.s2;
	assign in_ready = ld.s1;

	// Position-hold and other frames become bubbles right at the input
	assign keep = in_valid && (flight_mode == MODE_STABILIZED || flight_mode == MODE_MANUAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld.s1) v_s1 <= keep;
			if (ld.s2) v_s2 <= v_s1;
			if (ld.s3) v_s3 <= v_s2;
			if (ld.s4) v_s4 <= v_s3;
			if (ld.s5) v_s5 <= v_s4;
			if (ld_out) out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s1) man_s1 <= (flight_mode == MODE_MANUAL);
		if (ld.s2) man_s2 <= man_s1;
		if (ld.s3) man_s3 <= man_s2;
		if (ld.s4) man_s4 <= man_s3;
		if (ld.s5) man_s5 <= man_s4;
	end

	assign out_valid = out_valid_q;

	// Lanes
	logic signed [THRUST_W-1:0] thrust_s5;
	rcsam_lane_t                roll_l, pitch_l, yaw_l;

	rcsam_thrust_lane u_thrust (
		.clk              (clk),
		.ld               (ld),
		.throttle_count   (throttle_count),
		.min_count        (stick_min_q),
		.thrust_per_count (thrust_per_q),
		.thrust_floor     (thrust_floor_q),
		.thrust           (thrust_s5)
	);

	rcsam_expo_lane u_roll (
		.clk            (clk),
		.ld             (ld),
		.stick_count    (roll_count),
		.mid_count      (stick_mid_q),
		.inv_half_range (inv_half_q),
		.full_scale     (max_tilt_q),
		.lane           (roll_l)
	);

	rcsam_expo_lane u_pitch (
		.clk            (clk),
		.ld             (ld),
		.stick_count    (pitch_count),
		.mid_count      (stick_mid_q),
		.inv_half_range (inv_half_q),
		.full_scale     (max_tilt_q),
		.lane           (pitch_l)
	);

	rcsam_expo_lane u_yaw (
		.clk            (clk),
		.ld             (ld),
		.stick_count    (yaw_count),
		.mid_count      (stick_mid_q),
		.inv_half_range (inv_half_q),
		.full_scale     (max_yaw_q),
		.lane           (yaw_l)
	);

	rcsam_merge u_merge (
		.clk          (clk),
		.ld_out       (ld_out),
		.manual       (man_s5),
		.thrust       (thrust_s5),
		.roll         (roll_l),
		.pitch        (pitch_l),
		.yaw          (yaw_l),
		.thrust_cmd   (thrust_cmd),
		.roll_cmd     (roll_cmd),
		.pitch_cmd    (pitch_cmd),
		.yaw_rate_cmd (yaw_rate_cmd)
	);

endmodule

// File: src/rcsam_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsam_checker
// Port-level checks for the RC stick attitude command mapper, bound to the
// top level.
// ----------------------------------------------------------------------------
module rcsam_checker import rcsam_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [THRUST_W-1:0] thrust_cmd,
	input logic signed [CMD_W-1:0]    roll_cmd,
	input logic signed [CMD_W-1:0]    pitch_cmd,
	input logic signed [CMD_W-1:0]    yaw_rate_cmd
);

	localparam logic [CMD_W-1:0] CMD_MOST_NEG = CMD_W'(1) << (CMD_W - 1);

	// Reset empties the output register
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("out_valid high during reset");

	// A held result keeps its payload until the transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(thrust_cmd) && $stable(roll_cmd)
			&& $stable(pitch_cmd) && $stable(yaw_rate_cmd))
		else $error("stalled result changed");

	// With the output register empty the stall chain cannot hold the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("in_ready low while output is empty");

	// Curve magnitude never exceeds the full scale, so the most negative code is unused
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> roll_cmd != $signed(CMD_MOST_NEG) && pitch_cmd != $signed(CMD_MOST_NEG)
			&& yaw_rate_cmd != $signed(CMD_MOST_NEG))
		else $error("attitude command at most negative code");

endmodule

bind rc_stick_attitude_command_mapper rcsam_checker u_rcsam_checker (.*);

// File: dv/rc_stick_attitude_command_mapper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_stick_attitude_command_mapper_test
// Self-checking bench for the radio frame to attitude command mapper. Frames
// go in over valid/ready, each transfer is predicted on the spot (thrust line
// with saturation, expo curve per stick) and the commands coming out are
// checked in order, field by field. Directed frames cover the modes, the
// curve knee and register extremes; then an output hold-off fills the
// pipeline, and random traffic runs under several register settings and
// idle/stall profiles.
// ----------------------------------------------------------------------------
module rc_stick_attitude_command_mapper_test import rcsam_pkg::*;;

	localparam int     HALF_PERIOD    = 10;
	localparam int     RESET_CYCLES   = 12;
	localparam int     TAIL_CYCLES    = 12;
	localparam int     DRAIN_LIMIT    = 4000;
	localparam int     HOLD_CYCLES    = 300;
	localparam int     ROUNDS         = 8;
	localparam int     ROUND_COMMANDS = 180;
	localparam int     REPORT_LIMIT   = 10;
	localparam longint RUN_LIMIT_NS   = 64'd10_000_000;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	localparam longint          THRUST_SAT_HI = 64'sd8388607;
	localparam longint          THRUST_SAT_LO = -64'sd8388608;
	localparam longint          CMD_SAT_HI    = 64'sd524287;
	localparam longint          CMD_SAT_LO    = -64'sd524288;
	localparam longint unsigned UNIT          = 64'd1 << FRAC_BITS;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_profile_e;

	typedef struct {
		logic [MODE_W-1:0]     mode;
		logic [STICK_BITS-1:0] throttle;
		logic [STICK_BITS-1:0] roll;
		logic [STICK_BITS-1:0] pitch;
		logic [STICK_BITS-1:0] yaw;
	} stick_frame_t;

	typedef struct {
		logic signed [THRUST_W-1:0] thrust;
		logic signed [CMD_W-1:0]    roll;
		logic signed [CMD_W-1:0]    pitch;
		logic signed [CMD_W-1:0]    yaw_cmd;
	} attitude_cmd_t;

	typedef struct {
		logic [STICK_BITS-1:0] stick_min;
		logic [STICK_BITS-1:0] stick_mid;
		logic [INV_W-1:0]      inv_half;
		logic [THR_W-1:0]      thrust_per;
		logic [THR_W-1:0]      thrust_floor;
		logic [M_W-1:0]        max_tilt;
		logic [M_W-1:0]        max_yaw;
	} mapper_regs_t;

	localparam mapper_regs_t RESET_REGS = '{RST_STICK_MIN, RST_STICK_MID, RST_INV_HALF,
		RST_THRUST_PER, RST_THRUST_FLOOR, RST_MAX_TILT, RST_MAX_YAW};

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CFG_IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]      cfg_wdata;
	logic                       in_valid;
	logic                       in_ready;
	logic [MODE_W-1:0]          flight_mode;
	logic [STICK_BITS-1:0]      throttle_count;
	logic [STICK_BITS-1:0]      roll_count;
	logic [STICK_BITS-1:0]      pitch_count;
	logic [STICK_BITS-1:0]      yaw_count;
	logic                       out_valid;
	logic                       out_ready;
	logic signed [THRUST_W-1:0] thrust_cmd;
	logic signed [CMD_W-1:0]    roll_cmd;
	logic signed [CMD_W-1:0]    pitch_cmd;
	logic signed [CMD_W-1:0]    yaw_rate_cmd;

	mapper_regs_t  active_regs = RESET_REGS;
	attitude_cmd_t pending_cmds[$];
	int            send_idle_pct;
	int            recv_stall_pct;
	int            hold_request;
	int            hold_seen;
	int            hold_left;
	int            mismatch_count;
	int            frames_taken;
	int            commands_checked;
	int            dropped_frames;
	int            input_stall_cycles;
	int            settings_count;

	rc_stick_attitude_command_mapper uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.flight_mode    (flight_mode),
		.throttle_count (throttle_count),
		.roll_count     (roll_count),
		.pitch_count    (pitch_count),
		.yaw_count      (yaw_count),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.thrust_cmd     (thrust_cmd),
		.roll_cmd       (roll_cmd),
		.pitch_cmd      (pitch_cmd),
		.yaw_rate_cmd   (yaw_rate_cmd)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------
	function automatic logic signed [THRUST_W-1:0] thrust_from_throttle(
		input logic [STICK_BITS-1:0] throttle);
		longint offset;
		longint thrust;
		offset = longint'(throttle) - longint'(active_regs.stick_min);
		thrust = longint'(active_regs.thrust_floor) + offset * longint'(active_regs.thrust_per);
		if (thrust > THRUST_SAT_HI) thrust = THRUST_SAT_HI;
		if (thrust < THRUST_SAT_LO) thrust = THRUST_SAT_LO;
		return thrust[THRUST_W-1:0];
	endfunction

	function automatic logic signed [CMD_W-1:0] expo_curve(input logic [STICK_BITS-1:0] count,
		input logic [M_W-1:0] full_scale);
		longint          offset;
		longint          shaped;
		longint unsigned mag;
		longint unsigned x;
		longint unsigned x_sq;
		longint unsigned y;
		offset = longint'(count) - longint'(active_regs.stick_mid);
		mag = (offset < 0) ? -offset : offset;
		// magnitude is truncated, then clamped to one; sign goes on last
		x = (mag * active_regs.inv_half) >> (INV_FRAC - FRAC_BITS);
		if (x > UNIT) x = UNIT;
		if (x < UNIT / 2) begin
			x_sq = (x * x) >> FRAC_BITS;
			y = (64'd4 * full_scale * x_sq) / (64'd3 * UNIT);
		end else begin
			y = (full_scale * (64'd4 * x - UNIT)) / (64'd3 * UNIT);
		end
		shaped = (offset < 0) ? -longint'(y) : longint'(y);
		if (shaped > CMD_SAT_HI) shaped = CMD_SAT_HI;
		if (shaped < CMD_SAT_LO) shaped = CMD_SAT_LO;
		return shaped[CMD_W-1:0];
	endfunction

	function automatic bit predict_commands(input stick_frame_t f, output attitude_cmd_t c);
		c = '{default: '0};
		if (f.mode != MODE_STABILIZED && f.mode != MODE_MANUAL) return 1'b0;
		c.thrust = thrust_from_throttle(f.throttle);
		if (f.mode == MODE_MANUAL) begin
			c.roll    = expo_curve(f.roll, active_regs.max_tilt);
			c.pitch   = expo_curve(f.pitch, active_regs.max_tilt);
			c.yaw_cmd = expo_curve(f.yaw, active_regs.max_yaw);
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	function automatic void note_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) $display("ERROR @%0t: %s", $time, msg);
	endfunction

	always @(posedge clk) begin
		stick_frame_t  taken;
		attitude_cmd_t want;
		attitude_cmd_t got;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				taken = '{flight_mode, throttle_count, roll_count, pitch_count, yaw_count};
				frames_taken++;
				if (predict_commands(taken, want)) pending_cmds.push_back(want);
				else dropped_frames++;
			end
			if (in_valid && !in_ready) input_stall_cycles++;
			if (out_valid && out_ready) begin
				got = '{thrust_cmd, roll_cmd, pitch_cmd, yaw_rate_cmd};
				if (pending_cmds.size() == 0) begin
					note_failure($sformatf({"command with nothing pending: thrust %0d",
						" roll %0d pitch %0d yaw %0d"},
						got.thrust, got.roll, got.pitch, got.yaw_cmd));
				end else begin
					want = pending_cmds.pop_front();
					commands_checked++;
					if (got.thrust !== want.thrust || got.roll !== want.roll ||
						got.pitch !== want.pitch || got.yaw_cmd !== want.yaw_cmd) begin
						note_failure($sformatf({"command #%0d: thrust exp %0d got %0d,",
							" roll exp %0d got %0d, pitch exp %0d got %0d,",
							" yaw exp %0d got %0d"}, commands_checked,
							want.thrust, got.thrust, want.roll, got.roll, want.pitch, got.pitch,
							want.yaw_cmd, got.yaw_cmd));
					end
				end
			end
		end
	end

	// Output side: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		if (hold_request != hold_seen) begin
			hold_seen = hold_request;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic send_frame(input stick_frame_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		flight_mode    <= f.mode;
		throttle_count <= f.throttle;
		roll_count     <= f.roll;
		pitch_count    <= f.pitch;
		yaw_count      <= f.yaw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// Wait out every pending command, then the pipeline depth for dropped frames
	task automatic settle();
		int waited = 0;
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_cmds.size() != 0) begin
			note_failure($sformatf("%0d commands never came out", pending_cmds.size()));
			pending_cmds.delete();
		end
	endtask

	// Writes all registers with junk above each width, plus the spare index
	task automatic program_regs(input mapper_regs_t r);
		logic [CFG_DATA_W-1:0] noise;
		for (int i = 0; i <= int'(REG_MAX_YAW); i++) begin
			noise = CFG_DATA_W'($urandom());
			cfg_we    <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			case (i[CFG_IDX_W-1:0])
				REG_STICK_MIN:    cfg_wdata <= {noise[23:12], r.stick_min};
				REG_STICK_MID:    cfg_wdata <= {noise[23:12], r.stick_mid};
				REG_INV_HALF:     cfg_wdata <= r.inv_half;
				REG_THRUST_PER:   cfg_wdata <= {noise[23:20], r.thrust_per};
				REG_THRUST_FLOOR: cfg_wdata <= {noise[23:20], r.thrust_floor};
				REG_MAX_TILT:     cfg_wdata <= {noise[23:19], r.max_tilt};
				default:          cfg_wdata <= {noise[23:19], r.max_yaw};
			endcase
			@(posedge clk);
		end
		cfg_index <= REG_SPARE;
		cfg_wdata <= CFG_DATA_W'($urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
		active_regs = r;
		settings_count++;
	endtask

	task automatic set_idling(input idle_profile_e profile);
		case (profile)
			IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 51; recv_stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 51; end
			default:       begin send_idle_pct = 19; recv_stall_pct = 19; end
		endcase
	endtask

	function automatic logic [STICK_BITS-1:0] stick_draw(input logic [STICK_BITS-1:0] center);
		int v;
		case ($urandom_range(3))
			0:       v = int'(center) + int'($urandom_range(1200)) - 600;
			1:       v = int'($urandom_range(4095));
			2:       v = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 4095 : int'(center));
			default: v = int'(center) + int'($urandom_range(80)) - 40;
		endcase
		if (v < 0) v = 0;
		if (v > 4095) v = 4095;
		return v[STICK_BITS-1:0];
	endfunction

	function automatic stick_frame_t random_frame();
		stick_frame_t f;
		int unsigned  pick;
		pick = $urandom_range(99);
		if (pick < 12)      f.mode = MODE_POS_HOLD;
		else if (pick < 22) f.mode = MODE_OTHER;
		else if (pick < 45) f.mode = MODE_STABILIZED;
		else                f.mode = MODE_MANUAL;
		f.throttle = stick_draw(active_regs.stick_min);
		f.roll     = stick_draw(active_regs.stick_mid);
		f.pitch    = stick_draw(active_regs.stick_mid);
		f.yaw      = stick_draw(active_regs.stick_mid);
		return f;
	endfunction

	function automatic mapper_regs_t plausible_regs();
		mapper_regs_t r;
		int unsigned  span;
		span           = $urandom_range(1000, 150);
		r.stick_min    = STICK_BITS'($urandom_range(1500));
		r.stick_mid    = STICK_BITS'($urandom_range(2800, 1200));
		r.inv_half     = INV_W'((32'd1 << INV_FRAC) / span);
		r.thrust_per   = THR_W'($urandom_range(4000));
		r.thrust_floor = THR_W'($urandom_range(20000));
		r.max_tilt     = M_W'($urandom_range(100000));
		r.max_yaw      = M_W'($urandom_range(400000));
		return r;
	endfunction

	function automatic mapper_regs_t wild_regs();
		mapper_regs_t r;
		r.stick_min    = STICK_BITS'($urandom());
		r.stick_mid    = STICK_BITS'($urandom());
		r.inv_half     = INV_W'($urandom());
		r.thrust_per   = THR_W'($urandom());
		r.thrust_floor = THR_W'($urandom());
		r.max_tilt     = M_W'($urandom());
		r.max_yaw      = M_W'($urandom());
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_mode_handling();
		set_idling(IDLE_NONE);
		send_frame('{MODE_POS_HOLD, 12'd4095, 12'd4095, 12'd4095, 12'd4095});
		send_frame('{MODE_OTHER, 12'd0, 12'd0, 12'd0, 12'd0});
		send_frame('{MODE_STABILIZED, 12'd0, 12'd0, 12'd4095, 12'd1500});
		send_frame('{MODE_STABILIZED, 12'd4095, 12'd4095, 12'd0, 12'd1500});
		send_frame('{MODE_MANUAL, 12'd1000, 12'd1500, 12'd1500, 12'd1500});
		send_frame('{MODE_MANUAL, 12'd0, 12'd0, 12'd4095, 12'd0});
		send_frame('{MODE_MANUAL, 12'd4095, 12'd1750, 12'd1250, 12'd1751});
		send_frame('{MODE_MANUAL, 12'd999, 12'd1501, 12'd1499, 12'd1999});
		send_frame('{MODE_POS_HOLD, 12'd2000, 12'd1750, 12'd1250, 12'd3000});
		settle();
	endtask

	// Half range of 512 counts puts the knee and full scale on exact counts
	task automatic test_curve_knee();
		mapper_regs_t r;
		r           = RESET_REGS;
		r.stick_mid = 12'd2048;
		r.inv_half  = 24'd32768;
		program_regs(r);
		send_frame('{MODE_MANUAL, 12'd2048, 12'd2304, 12'd1792, 12'd2303});
		send_frame('{MODE_MANUAL, 12'd2048, 12'd2560, 12'd1536, 12'd2561});
		send_frame('{MODE_MANUAL, 12'd1000, 12'd2049, 12'd2047, 12'd2048});
		send_frame('{MODE_MANUAL, 12'd3000, 12'd2305, 12'd1791, 12'd1535});
		settle();
	endtask

	task automatic test_register_extremes();
		mapper_regs_t r;
		program_regs('{default: '0});
		send_frame('{MODE_MANUAL, 12'd4095, 12'd4095, 12'd4095, 12'd4095});
		send_frame('{MODE_MANUAL, 12'd0, 12'd0, 12'd0, 12'd0});
		send_frame('{MODE_STABILIZED, 12'd4095, 12'd4095, 12'd0, 12'd4095});
		settle();
		// everything at full scale: throttle below minimum saturates low
		program_regs('{12'hFFF, 12'hFFF, 24'hFFFFFF, 20'hFFFFF, 20'hFFFFF, 19'h7FFFF, 19'h7FFFF});
		send_frame('{MODE_MANUAL, 12'd0, 12'd0, 12'd4095, 12'd2000});
		send_frame('{MODE_MANUAL, 12'd4095, 12'd4095, 12'd4094, 12'd0});
		send_frame('{MODE_OTHER, 12'd0, 12'd0, 12'd0, 12'd0});
		settle();
		// zero minimum with steep slope saturates high
		r           = '{12'h000, 12'h000, 24'hFFFFFF, 20'hFFFFF, 20'hFFFFF, 19'h7FFFF, 19'h7FFFF};
		program_regs(r);
		send_frame('{MODE_MANUAL, 12'd4095, 12'd4095, 12'd0, 12'd1});
		send_frame('{MODE_STABILIZED, 12'd4095, 12'd1, 12'd2, 12'd3});
		settle();
	endtask

	task automatic test_output_backpressure();
		program_regs(RESET_REGS);
		set_idling(IDLE_NONE);
		hold_request++;
		repeat (80) send_frame(random_frame());
		settle();
	endtask

	task automatic test_random_traffic();
		stick_frame_t f;
		int           sent;
		for (int pass_idx = 0; pass_idx < ROUNDS; pass_idx++) begin
			if (pass_idx == 0) program_regs(RESET_REGS);
			else if (pass_idx % 3 == 2) program_regs(wild_regs());
			else program_regs(plausible_regs());
			set_idling(idle_profile_e'(pass_idx % 4));
			sent = 0;
			while (sent < ROUND_COMMANDS) begin
				f = random_frame();
				send_frame(f);
				if (f.mode == MODE_STABILIZED || f.mode == MODE_MANUAL) sent++;
			end
			settle();
		end
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		in_valid       = 1'b0;
		flight_mode    = MODE_POS_HOLD;
		throttle_count = '0;
		roll_count     = '0;
		pitch_count    = '0;
		yaw_count      = '0;
		out_ready      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 0;
		hold_seen      = 0;
		hold_left      = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_mode_handling();
		test_curve_knee();
		test_register_extremes();
		test_output_backpressure();
		test_random_traffic();

		$display({"Run covered %0d frames (%0d commands checked, %0d dropped by mode)",
			" over %0d register settings."},
			frames_taken, commands_checked, dropped_frames, settings_count);
		$display("Input was held off for %0d cycles; %0d mismatches.",
			input_stall_cycles, mismatch_count);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Timeout after %0d ns", RUN_LIMIT_NS);
		$display("FAILED: results differ");
		$finish;
	end

endmodule
